// ===== design/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// olist_pkg
// Shared constants, request codes and types of the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

  // Store geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = 6;   // index into the store
  localparam int CNT_W    = 7;   // entry count, 0 .. CAPACITY
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 4;
  localparam int STAT_W   = 2;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_REMOVE_AT  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_REMOVE_VAL = 4'd6;
  localparam logic [MODE_W-1:0] MODE_READ_AT    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_FRONT      = 4'd8;
  localparam logic [MODE_W-1:0] MODE_BACK       = 4'd9;
  localparam logic [MODE_W-1:0] MODE_SWAP       = 4'd10;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd11;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // One request from the input channel
  typedef struct packed {
    logic [IDX_W-1:0]         position_two;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic [MODE_W-1:0]        mode;
  } request_t;

  // One result for the output channel
  typedef struct packed {
    logic                     is_empty;
    logic [CNT_W-1:0]         count;
    logic                     found;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
  } result_t;

  // Store access issued by the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

// ===== design/ordered_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Bounded ordered list of signed 32-bit values with one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, one at a time; s_axis_tready is high
//   only while the sequencer is idle. Each request gives exactly one result on
//   the m_axis channel, held in an output register until it is taken.
//   Clear, refused or out-of-range requests go straight to the result. A read
//   issues one store read, a swap two reads and two writes, and a push at the
//   back one write. Insert and push front first shift the entries from the
//   position onward up by one place; pop, remove at and remove value walk the
//   entries from the position, or from the front, to the back. Entries move one
//   per cycle through the single read and single write port of the store.
//   A request may be accepted while the previous result still waits; its
//   result is held in the sequencer until the output register is free.
//   Reset empties the list at once (the count goes to zero); no clearing pass
//   is needed. A stalled receiver holds m_axis_tdata stable and, once the
//   sequencer has a result waiting, stops further requests.
// ----------------------------------------------------------------------------
module ordered_list_engine_core
  import olist_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] mode, [35:4] value, [42:36] position, [48:43] position_two,
  // [55:49] zero
  input  logic [55:0] s_axis_tdata,
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] data, [33:32] status, [34] found, [41:35] count, [42] is_empty,
  // [47:43] zero
  output logic [47:0] m_axis_tdata
);

  localparam int REQ_W = $bits(request_t);
  localparam int RES_W = $bits(result_t);

  request_t          req;
  result_t           res;
  logic              res_valid;
  logic              res_ack;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] rdata;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  assign req = request_t'(s_axis_tdata[REQ_W-1:0]);

  olist_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_i       (req),
    .req_ready_o (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ack_i   (res_ack),
    .mem_o       (mem_req),
    .rdata_i     (rdata)
  );

  olist_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Output register
  assign res_ack     = !out_valid_q || m_axis_tready;
  assign out_valid_d = res_valid || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(48 - RES_W){1'b0}}, out_q};

endmodule

// ===== design/olist_store.sv =====
// ----------------------------------------------------------------------------
// olist_store
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olist_store
  import olist_pkg::*;
(
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/olist_seq.sv =====
// ----------------------------------------------------------------------------
// olist_seq
// Request sequencer: decodes a request, checks it against the entry count and
// walks the store one entry per cycle to open a gap, close a gap or search;
// reads and swaps access single entries.
// ----------------------------------------------------------------------------
module olist_seq
  import olist_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request side
  input  logic              req_valid_i,
  input  request_t          req_i,
  output logic              req_ready_o,
  // result side
  output logic              res_valid_o,
  output result_t           res_o,
  input  logic              res_ack_i,
  // store port
  output mem_req_t          mem_o,
  input  logic [DATA_W-1:0] rdata_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_STREAM = 4'd1;
  localparam logic [3:0] S_WRVAL  = 4'd2;
  localparam logic [3:0] S_RD0    = 4'd3;
  localparam logic [3:0] S_RD1    = 4'd4;
  localparam logic [3:0] S_SW0    = 4'd5;
  localparam logic [3:0] S_SW1    = 4'd6;
  localparam logic [3:0] S_SW2    = 4'd7;
  localparam logic [3:0] S_SW3    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  pos2_q, pos2_d;
  logic [IDX_W-1:0]  rp_q, rp_d;       // next address to read
  logic [IDX_W-1:0]  last_q, last_d;   // last address of an upward walk
  logic              more_q, more_d;   // reads still to issue
  logic              v_q, v_d;         // read data in flight
  logic [IDX_W-1:0]  j_q, j_d;         // address of the data in flight
  logic              up_q, up_d;       // walk direction, 1 = upward
  logic              rm_at_q, rm_at_d; // remove by position, not by value
  logic              hit_q, hit_d;     // removal point passed
  logic [DATA_W-1:0] taken_q, taken_d;
  logic [DATA_W-1:0] rdat_q, rdat_d;   // result data
  logic [STAT_W-1:0] stat_q, stat_d;
  logic              found_q, found_d;

  logic [CNT_W-1:0]  eff_pos;
  logic [CNT_W-1:0]  swap_hi;
  logic              hit_now;

  // Effective position of the request
  always_comb begin
    case (req_i.mode) inside
      MODE_PUSH_FRONT, MODE_POP_FRONT, MODE_FRONT: eff_pos = '0;
      MODE_PUSH_BACK:                              eff_pos = cnt_q;
      MODE_POP_BACK, MODE_BACK:                    eff_pos = cnt_q - CNT_ONE;
      default:                                     eff_pos = req_i.position;
    endcase
  end

  assign swap_hi = (req_i.position > {1'b0, req_i.position_two}) ?
                   req_i.position : {1'b0, req_i.position_two};

  // Removal point: the given position, or the first entry equal to value
  assign hit_now = rm_at_q ? (j_q == pos_q) : (rdata_i == val_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    pos_d   = pos_q;
    pos2_d  = pos2_q;
    rp_d    = rp_q;
    last_d  = last_q;
    more_d  = more_q;
    v_d     = 1'b0;
    j_d     = j_q;
    up_d    = up_q;
    rm_at_d = rm_at_q;
    hit_d   = hit_q;
    taken_d = taken_q;
    rdat_d  = rdat_q;
    stat_d  = stat_q;
    found_d = found_q;
    mem_o   = '{we: 1'b0, waddr: pos_q, wdata: val_q, raddr: rp_q};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          val_d   = req_i.value;
          rdat_d  = '0;
          stat_d  = STAT_OK;
          found_d = 1'b0;
          hit_d   = 1'b0;
          pos_d   = eff_pos[IDX_W-1:0];
          pos2_d  = req_i.position_two;
          last_d  = IDX_W'(cnt_q - CNT_ONE);
          state_d = S_DONE;
          unique case (req_i.mode) inside
            MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
              if (eff_pos > cnt_q) begin
                stat_d = STAT_BAD;
              end else if (cnt_q >= CNT_CAP) begin
                stat_d = STAT_FULL;
              end else if (eff_pos == cnt_q) begin
                state_d = S_WRVAL;
              end else begin
                rp_d    = IDX_W'(cnt_q - CNT_ONE);
                more_d  = 1'b1;
                up_d    = 1'b0;
                state_d = S_STREAM;
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE_AT: begin
              if (cnt_q == '0 || eff_pos >= cnt_q) begin
                stat_d = STAT_BAD;
              end else begin
                rp_d    = eff_pos[IDX_W-1:0];
                more_d  = 1'b1;
                up_d    = 1'b1;
                rm_at_d = 1'b1;
                state_d = S_STREAM;
              end
            end
            MODE_REMOVE_VAL: begin
              if (cnt_q != '0) begin
                rp_d    = '0;
                more_d  = 1'b1;
                up_d    = 1'b1;
                rm_at_d = 1'b0;
                state_d = S_STREAM;
              end
            end
            MODE_READ_AT, MODE_FRONT, MODE_BACK: begin
              if (cnt_q == '0 || eff_pos >= cnt_q) begin
                stat_d = STAT_BAD;
              end else begin
                state_d = S_RD0;
              end
            end
            MODE_SWAP: begin
              if (req_i.position != {1'b0, req_i.position_two}) begin
                if (swap_hi >= cnt_q) begin
                  stat_d = STAT_BAD;
                end else begin
                  state_d = S_SW0;
                end
              end
            end
            MODE_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
              stat_d = STAT_BAD;
            end
          endcase
        end
      end

      // Walk the store: one read issued per cycle, moving entries one per cycle
      S_STREAM: begin
        if (more_q) begin
          mem_o.raddr = rp_q;
          v_d         = 1'b1;
          j_d         = rp_q;
          if (up_q) begin
            if (rp_q == last_q) more_d = 1'b0;
            else                rp_d   = rp_q + IDX_ONE;
          end else begin
            if (rp_q == pos_q) more_d = 1'b0;
            else               rp_d   = rp_q - IDX_ONE;
          end
        end
        if (v_q) begin
          if (!up_q) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = j_q + IDX_ONE;
            mem_o.wdata = rdata_i;
          end else if (hit_q) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = j_q - IDX_ONE;
            mem_o.wdata = rdata_i;
          end else if (hit_now) begin
            hit_d   = 1'b1;
            taken_d = rdata_i;
          end
        end
        if (!more_q && !v_q) begin
          if (!up_q) begin
            state_d = S_WRVAL;
          end else begin
            if (hit_q) begin
              cnt_d   = cnt_q - CNT_ONE;
              rdat_d  = taken_q;
              found_d = !rm_at_q;
            end
            state_d = S_DONE;
          end
        end
      end

      S_WRVAL: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        mem_o.wdata = val_q;
        cnt_d       = cnt_q + CNT_ONE;
        state_d     = S_DONE;
      end

      S_RD0: begin
        mem_o.raddr = pos_q;
        state_d     = S_RD1;
      end

      S_RD1: begin
        rdat_d  = rdata_i;
        state_d = S_DONE;
      end

      // Swap: read both, then write each into the other's place
      S_SW0: begin
        mem_o.raddr = pos_q;
        state_d     = S_SW1;
      end

      S_SW1: begin
        mem_o.raddr = pos2_q;
        taken_d     = rdata_i;
        state_d     = S_SW2;
      end

      S_SW2: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        mem_o.wdata = rdata_i;
        state_d     = S_SW3;
      end

      S_SW3: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos2_q;
        mem_o.wdata = taken_q;
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (res_ack_i) state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      more_q  <= 1'b0;
      v_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      more_q  <= more_d;
      v_q     <= v_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    pos_q   <= pos_d;
    pos2_q  <= pos2_d;
    rp_q    <= rp_d;
    last_q  <= last_d;
    j_q     <= j_d;
    up_q    <= up_d;
    rm_at_q <= rm_at_d;
    hit_q   <= hit_d;
    taken_q <= taken_d;
    rdat_q  <= rdat_d;
    stat_q  <= stat_d;
    found_q <= found_d;
  end

  assign req_ready_o    = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_DONE);
  assign res_o.data     = rdat_q;
  assign res_o.status   = stat_q;
  assign res_o.found    = found_q;
  assign res_o.count    = cnt_q;
  assign res_o.is_empty = (cnt_q == '0);

endmodule

// ===== sim/ordered_list_engine_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_engine_core_tb
// Self-checking bench for the ordered list engine. A short directed run
// covers the empty list, bad positions, unused modes and every request
// kind. A long random run follows. It grows, drains and churns the list,
// so the store fills up and empties several times. A shadow list computes
// the expected result of each accepted request. The monitor checks each
// returned result against that prediction.
// ----------------------------------------------------------------------------
module ordered_list_engine_core_tb;
  import olist_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_REQS  = 1300;
  localparam int PHASE_LEN    = 200;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

  // list trend of a random phase
  localparam int TREND_GROW   = 0;
  localparam int TREND_SHRINK = 1;
  localparam int TREND_MIXED  = 2;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [3:0] mode, [35:4] value, [42:36] position, [48:43] position_two
  logic [55:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [31:0] data, [33:32] status, [34] found, [41:35] count, [42] is_empty
  logic [47:0] m_axis_tdata;

  // shadow copy of the list
  logic [DATA_W-1:0] list_store [CAPACITY];
  int                list_count = 0;

  request_t pending_requests [$];
  result_t  expected_results [$];

  int      tx_gap;
  logic    tx_quiet;
  int      rx_stall;
  int      rx_draw;
  logic    rx_quiet;
  int      cycle_count = 0;
  logic    failed      = 1'b0;
  int      trend;
  result_t got;
  result_t want;

  ordered_list_engine_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Remove one entry from the shadow list and close the gap behind it
  function automatic logic [DATA_W-1:0] take_entry(int at);
    logic [DATA_W-1:0] taken;
    int                i;
    taken = list_store[at];
    for (i = at; i + 1 < list_count; i++) list_store[i] = list_store[i + 1];
    list_count--;
    return taken;
  endfunction

  // Apply one request to the shadow list and return the result it gives
  function automatic result_t apply_list_request(request_t r);
    result_t           res;
    int                at;
    int                hi;
    int                i;
    logic [DATA_W-1:0] tmp;
    res        = '0;
    res.status = STAT_OK;
    case (r.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
        if (r.mode == MODE_PUSH_FRONT) at = 0;
        else if (r.mode == MODE_PUSH_BACK) at = list_count;
        else at = int'(r.position);
        // a bad position wins over a full store
        if (at > list_count) begin
          res.status = STAT_BAD;
        end else if (list_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          for (i = list_count; i > at; i--) list_store[i] = list_store[i - 1];
          list_store[at] = r.value;
          list_count++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE_AT: begin
        if (r.mode == MODE_POP_FRONT) at = 0;
        else if (r.mode == MODE_POP_BACK) at = list_count - 1;
        else at = int'(r.position);
        if (list_count == 0 || at >= list_count) res.status = STAT_BAD;
        else res.data = take_entry(at);
      end
      MODE_REMOVE_VAL: begin
        // first match only; a miss is not an error
        for (i = 0; i < list_count; i++) begin
          if (list_store[i] == r.value) begin
            res.data  = take_entry(i);
            res.found = 1'b1;
            break;
          end
        end
      end
      MODE_READ_AT, MODE_FRONT, MODE_BACK: begin
        if (r.mode == MODE_FRONT) at = 0;
        else if (r.mode == MODE_BACK) at = list_count - 1;
        else at = int'(r.position);
        if (list_count == 0 || at >= list_count) res.status = STAT_BAD;
        else res.data = list_store[at];
      end
      MODE_SWAP: begin
        // equal positions are a no-op even when out of range
        if (int'(r.position) != int'(r.position_two)) begin
          hi = (int'(r.position) > int'(r.position_two)) ?
               int'(r.position) : int'(r.position_two);
          if (hi >= list_count) begin
            res.status = STAT_BAD;
          end else begin
            tmp                          = list_store[r.position];
            list_store[r.position]       = list_store[r.position_two];
            list_store[r.position_two]   = tmp;
          end
        end
      end
      MODE_CLEAR: list_count = 0;
      default:    res.status = STAT_BAD;
    endcase
    res.count    = CNT_W'(list_count);
    res.is_empty = (list_count == 0);
    return res;
  endfunction

  function automatic void queue_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value,
                                        int position, int position_two);
    request_t r;
    r.mode         = mode;
    r.value        = value;
    r.position     = CNT_W'(position);
    r.position_two = IDX_W'(position_two);
    pending_requests.push_back(r);
  endfunction

  // Random request shaped by the current list length and the phase trend
  function automatic request_t draw_request(int cnt, int phase_trend);
    request_t r;
    int       roll;
    int       add_w;
    int       take_w;
    r = '0;
    case (phase_trend)
      TREND_GROW:   begin add_w = 55; take_w = 5;  end
      TREND_SHRINK: begin add_w = 15; take_w = 45; end
      default:      begin add_w = 30; take_w = 30; end
    endcase

    roll = $urandom_range(0, 99);
    if (roll < add_w) begin
      case ($urandom_range(0, 2))
        0:       r.mode = MODE_PUSH_FRONT;
        1:       r.mode = MODE_PUSH_BACK;
        default: r.mode = MODE_INSERT;
      endcase
    end else if (roll < add_w + take_w) begin
      case ($urandom_range(0, 3))
        0:       r.mode = MODE_POP_FRONT;
        1:       r.mode = MODE_POP_BACK;
        2:       r.mode = MODE_REMOVE_AT;
        default: r.mode = MODE_REMOVE_VAL;
      endcase
    end else if (roll < 82 || roll == 94 || (roll >= 97 && roll < 99)) begin
      case ($urandom_range(0, 2))
        0:       r.mode = MODE_READ_AT;
        1:       r.mode = MODE_FRONT;
        default: r.mode = MODE_BACK;
      endcase
    end else if (roll < 94) begin
      r.mode = MODE_SWAP;
    end else if (roll < 97) begin
      r.mode = MODE_CLEAR + MODE_W'($urandom_range(1, 4));   // unused codes
    end else begin
      r.mode = (phase_trend == TREND_MIXED) ? MODE_CLEAR : MODE_BACK;
    end

    // small pool so value searches hit often
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      r.value = $signed($urandom_range(0, 15)) - 8;
    end else if (roll < 60) begin
      case ($urandom_range(0, 3))
        0:       r.value = 32'h8000_0000;
        1:       r.value = 32'h7FFF_FFFF;
        2:       r.value = '0;
        default: r.value = '1;
      endcase
    end else begin
      r.value = $urandom();
    end

    // positions mostly near the valid range, sometimes anywhere
    if ($urandom_range(0, 3) != 0) r.position = CNT_W'($urandom_range(0, cnt));
    else r.position = CNT_W'($urandom_range(0, CAPACITY));
    if ($urandom_range(0, 3) != 0)
      r.position_two = IDX_W'($urandom_range(0, (cnt > 0) ? cnt - 1 : 0));
    else
      r.position_two = IDX_W'($urandom_range(0, CAPACITY - 1));
    return r;
  endfunction

  // Request driver: draws a random idle gap after each request, none while quiet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tx_gap        <= 0;
      tx_quiet      <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_list_request(s_axis_tdata[48:0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          tx_gap        <= tx_gap - 1;
        end else if (pending_requests.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, pending_requests.pop_front()};
          tx_gap        <= tx_quiet ? 0 : $urandom_range(0, 3);
          if ($urandom_range(0, 63) == 0) tx_quiet <= !tx_quiet;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each result, then draw a random stall, none while quiet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall      <= 0;
      rx_quiet      <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          got  = m_axis_tdata[42:0];
          if (got.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, got.data);
            failed = 1'b1;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failed = 1'b1;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            failed = 1'b1;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            failed = 1'b1;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            failed = 1'b1;
          end
        end
        rx_draw = rx_quiet ? 0 : $urandom_range(0, 3);
        rx_stall      <= rx_draw;
        m_axis_tready <= (rx_draw == 0);
        if ($urandom_range(0, 63) == 0) rx_quiet <= !rx_quiet;
      end else if (rx_stall != 0) begin
        rx_stall      <= rx_stall - 1;
        m_axis_tready <= (rx_stall == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    // empty list: every read and positional removal is refused; a value removal misses
    queue_request(MODE_POP_FRONT,  32'd0, 0, 0);
    queue_request(MODE_POP_BACK,   32'd0, 0, 0);
    queue_request(MODE_FRONT,      32'd0, 0, 0);
    queue_request(MODE_BACK,       32'd0, 0, 0);
    queue_request(MODE_READ_AT,    32'd0, 0, 0);
    queue_request(MODE_REMOVE_AT,  32'd0, 0, 0);
    queue_request(MODE_REMOVE_VAL, 32'd5, 0, 0);
    queue_request(MODE_SWAP,       32'd0, 5, 5);    // equal, out of range: ok
    queue_request(MODE_SWAP,       32'd0, 0, 1);
    queue_request(MODE_INSERT,     32'd1, 1, 0);    // past the end
    queue_request(MODE_CLEAR + 4'd1, 32'd0, 0, 0);
    queue_request(MODE_CLEAR + 4'd4, '1, 127, 63);
    // build [-1, 0, min, max] by every add path
    queue_request(MODE_PUSH_FRONT, 32'h8000_0000, 0, 0);
    queue_request(MODE_PUSH_BACK,  32'h7FFF_FFFF, 0, 0);
    queue_request(MODE_INSERT,     32'hFFFF_FFFF, 0, 0);
    queue_request(MODE_INSERT,     32'd0, 1, 0);
    queue_request(MODE_READ_AT,    32'd0, 3, 0);
    queue_request(MODE_FRONT,      32'd0, 0, 0);
    queue_request(MODE_BACK,       32'd0, 0, 0);
    queue_request(MODE_SWAP,       32'd0, 0, 3);
    queue_request(MODE_REMOVE_VAL, 32'd0, 0, 0);
    queue_request(MODE_REMOVE_AT,  32'd0, 1, 0);
    queue_request(MODE_READ_AT,    32'd0, 64, 0);
    queue_request(MODE_SWAP,       32'd0, 0, 63);
    queue_request(MODE_CLEAR,      32'd0, 0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // random phases: grow to full, drain, churn
    for (int n = 0; n < RANDOM_REQS; n++) begin
      while (pending_requests.size() > 1) @(negedge clk_i);
      trend = (n / PHASE_LEN) % 3;
      pending_requests.push_back(draw_request(list_count, trend));
    end

    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
